// File: sv/e3q_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants of the Euler 321 to quaternion block.
// Depends on nothing; every other file imports it.
package e3q_pkg;

  // Field widths of the item payloads.
  localparam int ANGLE_BITS   = 16;
  localparam int QUAT_BITS    = 16;
  localparam int CORDIC_STEPS = 16;

  // Internal widths: rotation coordinates and angles in Q30 with headroom.
  localparam int ZW      = 36;
  localparam int XW      = 36;
  localparam int MW      = 36;
  localparam int TW      = 72;
  localparam int STEP_W  = 5;
  localparam int ZSHIFT  = 33 - ANGLE_BITS;
  localparam int RND_SH  = 62 - QUAT_BITS;
  localparam int RW      = TW + 1 - RND_SH;

  // Q30 constants: pi, pi/2 and the gain-compensated CORDIC start value.
  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [XW-1:0] X0_Q30      = 36'sd652032874;
  localparam logic signed [RW-1:0] QUAT_LIM    = RW'(64'sd1 <<< (QUAT_BITS - 2));

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
  } e3q_angles_t;

  typedef struct packed {
    logic signed [QUAT_BITS-1:0] quat_w;
    logic signed [QUAT_BITS-1:0] quat_x;
    logic signed [QUAT_BITS-1:0] quat_y;
    logic signed [QUAT_BITS-1:0] quat_z;
  } e3q_quat_t;

  // One angle under rotation: residual angle, cosine and sine, and whether
  // the half angle was folded by pi.
  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic                 neg;
  } e3q_rot_t;

  // Roll at index 0, pitch at 1, yaw at 2.
  typedef e3q_rot_t [2:0] e3q_trio_t;

  // Rounded atan(2^-i) in Q30.
  function automatic logic signed [ZW-1:0] atan_q30(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:    r = 36'sd843314857;
      5'd1:    r = 36'sd497837829;
      5'd2:    r = 36'sd263043837;
      5'd3:    r = 36'sd133525159;
      5'd4:    r = 36'sd67021687;
      5'd5:    r = 36'sd33543516;
      5'd6:    r = 36'sd16775851;
      5'd7:    r = 36'sd8388437;
      5'd8:    r = 36'sd4194283;
      5'd9:    r = 36'sd2097149;
      5'd10:   r = 36'sd1048576;
      5'd11:   r = 36'sd524288;
      default: r = ZW'(64'sd1 <<< (30 - {27'd0, i}));
    endcase
    return r;
  endfunction

endpackage

// File: sv/e3q_reduce.sv
`timescale 1ns / 1ps
// Input stage: widens the three angles to Q30 half angles and folds them into +/- pi/2.
// Depends on e3q_pkg.
module e3q_reduce import e3q_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  e3q_angles_t up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output e3q_trio_t   dn_data
);

  logic      v;
  e3q_trio_t data;
  e3q_trio_t data_next;

  function automatic e3q_rot_t fold(input logic signed [ANGLE_BITS-1:0] a);
    e3q_rot_t r;
    logic signed [ZW-1:0] z0;
    z0 = {{(ZW - ANGLE_BITS){a[ANGLE_BITS-1]}}, a} <<< ZSHIFT;
    r.x = X0_Q30;
    r.y = '0;
    if (z0 > HALF_PI_Q30) begin
      r.z = z0 - PI_Q30;
      r.neg = 1'b1;
    end else if (z0 < -HALF_PI_Q30) begin
      r.z = z0 + PI_Q30;
      r.neg = 1'b1;
    end else begin
      r.z = z0;
      r.neg = 1'b0;
    end
    return r;
  endfunction

  // Fold each half angle and load the CORDIC start vector.
  always_comb begin
    data_next[0] = fold(up_data.roll_angle);
    data_next[1] = fold(up_data.pitch_angle);
    data_next[2] = fold(up_data.yaw_angle);
  end

  assign up_ready = !v || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (up_ready) begin
      v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = v;
  assign dn_data  = data;

endmodule

// File: sv/e3q_cordic_stage.sv
`timescale 1ns / 1ps
// One rotation-mode CORDIC iteration applied to all three angles, with its register.
// Depends on e3q_pkg.
module e3q_cordic_stage import e3q_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [STEP_W-1:0] step,
  input  logic              up_valid,
  output logic              up_ready,
  input  e3q_trio_t         up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output e3q_trio_t         dn_data
);

  logic      v;
  e3q_trio_t data;
  e3q_trio_t data_next;

  // Rotate toward zero residual angle; zero counts as positive.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      data_next[k].neg = up_data[k].neg;
      if (!up_data[k].z[ZW-1]) begin
        data_next[k].x = up_data[k].x - (up_data[k].y >>> step);
        data_next[k].y = up_data[k].y + (up_data[k].x >>> step);
        data_next[k].z = up_data[k].z - atan_q30(step);
      end else begin
        data_next[k].x = up_data[k].x + (up_data[k].y >>> step);
        data_next[k].y = up_data[k].y - (up_data[k].x >>> step);
        data_next[k].z = up_data[k].z + atan_q30(step);
      end
    end
  end

  assign up_ready = !v || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (up_ready) begin
      v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = v;
  assign dn_data  = data;

endmodule

// File: sv/e3q_combine.sv
`timescale 1ns / 1ps
// Three-stage product tree: pairwise Q30 products, third-factor products,
// then sum, rounding and saturation into the output register. Depends on e3q_pkg.
module e3q_combine import e3q_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  output logic      up_ready,
  input  e3q_trio_t up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output e3q_quat_t dn_data
);

  logic v1, v2, v3;
  logic r1, r2, r3;

  logic signed [XW-1:0] cr, sr, cp, sp, cy, sy;
  logic signed [MW-1:0] crcp_next, srsp_next, srcp_next, crsp_next;
  logic signed [MW-1:0] crcp, srsp, srcp, crsp;
  logic signed [XW-1:0] cy1, sy1;
  logic signed [TW-1:0] tw1_next, tw2_next, tx1_next, tx2_next;
  logic signed [TW-1:0] ty1_next, ty2_next, tz1_next, tz2_next;
  logic signed [TW-1:0] tw1, tw2, tx1, tx2, ty1, ty2, tz1, tz2;
  e3q_quat_t            quat_next;
  e3q_quat_t            quat;

  function automatic logic signed [MW-1:0] mul_q30(input logic signed [XW-1:0] a,
                                                   input logic signed [XW-1:0] b);
    logic signed [TW-1:0] p;
    p = TW'(a) * TW'(b) + (TW'(1) <<< 29);
    return p[MW+29:30];
  endfunction

  function automatic logic signed [QUAT_BITS-1:0] finish(input logic signed [TW-1:0] p,
                                                         input logic signed [TW-1:0] q,
                                                         input logic minus);
    logic signed [TW:0]   s;
    logic signed [RW-1:0] r;
    if (minus) begin
      s = {p[TW-1], p} - {q[TW-1], q};
    end else begin
      s = {p[TW-1], p} + {q[TW-1], q};
    end
    s = s + ((TW+1)'(1) <<< (RND_SH - 1));
    r = s[TW:RND_SH];
    if (r > QUAT_LIM) begin
      r = QUAT_LIM;
    end else if (r < -QUAT_LIM) begin
      r = -QUAT_LIM;
    end
    return r[QUAT_BITS-1:0];
  endfunction

  // Undo the pi fold, then the four distinct pairwise products.
  always_comb begin
    cr = up_data[0].neg ? -up_data[0].x : up_data[0].x;
    sr = up_data[0].neg ? -up_data[0].y : up_data[0].y;
    cp = up_data[1].neg ? -up_data[1].x : up_data[1].x;
    sp = up_data[1].neg ? -up_data[1].y : up_data[1].y;
    cy = up_data[2].neg ? -up_data[2].x : up_data[2].x;
    sy = up_data[2].neg ? -up_data[2].y : up_data[2].y;
    crcp_next = mul_q30(cr, cp);
    srsp_next = mul_q30(sr, sp);
    srcp_next = mul_q30(sr, cp);
    crsp_next = mul_q30(cr, sp);
  end

  // Each pair times the yaw term, Q60.
  always_comb begin
    tw1_next = TW'(crcp) * TW'(cy1);
    tw2_next = TW'(srsp) * TW'(sy1);
    tx1_next = TW'(srcp) * TW'(cy1);
    tx2_next = TW'(crsp) * TW'(sy1);
    ty1_next = TW'(crsp) * TW'(cy1);
    ty2_next = TW'(srcp) * TW'(sy1);
    tz1_next = TW'(crcp) * TW'(sy1);
    tz2_next = TW'(srsp) * TW'(cy1);
  end

  // Sum, round to the output format and clamp to plus or minus one.
  always_comb begin
    quat_next.quat_w = finish(tw1, tw2, 1'b0);
    quat_next.quat_x = finish(tx1, tx2, 1'b1);
    quat_next.quat_y = finish(ty1, ty2, 1'b0);
    quat_next.quat_z = finish(tz1, tz2, 1'b1);
  end

  // Stage handshake: a stage loads when empty or when its successor moves.
  assign r3 = !v3 || dn_ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign up_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= up_valid;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && up_valid) begin
      crcp <= crcp_next;
      srsp <= srsp_next;
      srcp <= srcp_next;
      crsp <= crsp_next;
      cy1  <= cy;
      sy1  <= sy;
    end
    if (r2 && v1) begin
      tw1 <= tw1_next;
      tw2 <= tw2_next;
      tx1 <= tx1_next;
      tx2 <= tx2_next;
      ty1 <= ty1_next;
      ty2 <= ty2_next;
      tz1 <= tz1_next;
      tz2 <= tz2_next;
    end
    if (r3 && v2) begin
      quat <= quat_next;
    end
  end

  assign dn_valid = v3;
  assign dn_data  = quat;

endmodule

// File: sv/euler321_to_quaternion_top.sv
`timescale 1ns / 1ps
// Euler 321 (roll, pitch, yaw) to unit quaternion converter, top level.
// Depends on e3q_pkg, e3q_reduce, e3q_cordic_stage and e3q_combine.
//
// Usage:
//   An item on the angles channel carries roll, pitch and yaw as signed Q4.12
//   radians; it is taken at a clock edge with angles_valid high and
//   angles_stall low. The matching item on the quat channel carries w, x, y, z
//   as signed Q2.14, each clamped to plus or minus one.
//   When the output is not stalled, an item passes through one fold stage,
//   one register per CORDIC iteration (16), and three product stages.
//   Throughput is one item per cycle while quat_stall is low; every stage holds one item.
//   When quat_stall is high the last stage holds its item unchanged; earlier
//   stages keep filling empty slots, and angles_stall rises only once the
//   first stage is full and cannot move on.
//   A synchronous reset empties the pipeline; nothing else is stored.
module euler321_to_quaternion_top import e3q_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        angles_valid,
  output logic        angles_stall,
  input  e3q_angles_t angles,
  output logic        quat_valid,
  input  logic        quat_stall,
  output e3q_quat_t   quat
);

  logic [CORDIC_STEPS:0] cv;
  logic [CORDIC_STEPS:0] crdy;
  e3q_trio_t             cd [CORDIC_STEPS+1];
  logic                  in_ready;

  // Fold stage.
  e3q_reduce u_reduce (
    .clk      (clk),
    .rst      (rst),
    .up_valid (angles_valid),
    .up_ready (in_ready),
    .up_data  (angles),
    .dn_valid (cv[0]),
    .dn_ready (crdy[0]),
    .dn_data  (cd[0])
  );

  // One register stage per CORDIC iteration.
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    e3q_cordic_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .step     (STEP_W'(g)),
      .up_valid (cv[g]),
      .up_ready (crdy[g]),
      .up_data  (cd[g]),
      .dn_valid (cv[g+1]),
      .dn_ready (crdy[g+1]),
      .dn_data  (cd[g+1])
    );
  end

  // Products, rounding and output register.
  e3q_combine u_combine (
    .clk      (clk),
    .rst      (rst),
    .up_valid (cv[CORDIC_STEPS]),
    .up_ready (crdy[CORDIC_STEPS]),
    .up_data  (cd[CORDIC_STEPS]),
    .dn_valid (quat_valid),
    .dn_ready (!quat_stall),
    .dn_data  (quat)
  );

  assign angles_stall = !in_ready;

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk) rst |=> !quat_valid)
    else $error("output valid right after reset");
  a_w_bound: assert property (@(posedge clk) disable iff (rst)
    quat_valid |-> (quat.quat_w <= $signed(QUAT_LIM[QUAT_BITS-1:0]) &&
                    quat.quat_w >= -$signed(QUAT_LIM[QUAT_BITS-1:0])))
    else $error("quat_w outside plus or minus one");
  a_x_bound: assert property (@(posedge clk) disable iff (rst)
    quat_valid |-> (quat.quat_x <= $signed(QUAT_LIM[QUAT_BITS-1:0]) &&
                    quat.quat_x >= -$signed(QUAT_LIM[QUAT_BITS-1:0])))
    else $error("quat_x outside plus or minus one");
  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !cv[0] |-> !angles_stall)
    else $error("input stalled while the first stage is empty");
`endif

endmodule
